// ===== hw/rtl/fir_ibcl_pkg.sv =====
// Shared types and constants for the in-band coefficient load FIR filter.
package fir_ibcl_pkg;

    localparam int WORD_W      = 32;
    localparam int RESULT_W    = 40;
    localparam int TAP_IDX_W   = 7;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [WORD_W-1:0] START_MARK = 32'h0000_BEEF;
    localparam logic [WORD_W-1:0] RUN_MARK   = 32'h0000_ABBA;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_LOAD,
        MODE_AWAIT,
        MODE_FILTER
    } mode_t;

    typedef enum logic [1:0] {
        CMD_COEF,
        CMD_SAMPLE,
        CMD_ABORT
    } cmd_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_MAC,
        BACK_DRAIN,
        BACK_RESULT
    } back_state_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] word;
        logic                     end_of_packet;
    } in_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] filtered;
        logic                       last_out;
    } out_t;

    typedef struct packed {
        cmd_t                 cmd;
        logic [TAP_IDX_W-1:0] addr;
        logic [WORD_W-1:0]    word;
        logic                 last;
    } cmd_entry_t;

    typedef struct packed {
        logic       valid;
        cmd_entry_t entry;
    } queue_head_t;

endpackage

// ===== hw/rtl/fir_ibcl_if.sv =====
// Valid/ready stream interfaces for the input words and the filter results.
interface fir_ibcl_in_if;
    logic                valid;
    logic                ready;
    fir_ibcl_pkg::in_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface fir_ibcl_out_if;
    logic                valid;
    logic                ready;
    fir_ibcl_pkg::out_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/fir_ibcl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fir_ibcl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/fir_ibcl_front.sv =====
// Front end: accepts stream words, tracks the packet mode and issues commands.
module fir_ibcl_front #(
    parameter int TAPS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    fir_ibcl_in_if.sink                   words,
    input  logic                          q_full,
    output logic                          q_push,
    output fir_ibcl_pkg::cmd_entry_t      q_entry
);

    localparam int IDX_W = $clog2(TAPS);

    fir_ibcl_pkg::mode_t mode_reg, mode_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                xfer;

    assign words.ready = !q_full;
    assign xfer        = words.valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= fir_ibcl_pkg::MODE_IDLE;
            idx_reg  <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            idx_reg  <= idx_next;
        end
    end

    always_comb
    begin
        mode_next     = mode_reg;
        idx_next      = idx_reg;
        q_push        = 1'b0;
        q_entry.cmd   = fir_ibcl_pkg::CMD_SAMPLE;
        q_entry.addr  = fir_ibcl_pkg::TAP_IDX_W'(IDX_W'(TAPS - 1) - idx_reg);
        q_entry.word  = words.payload.word;
        q_entry.last  = words.payload.end_of_packet;
        if (xfer)
        begin
            if (mode_reg == fir_ibcl_pkg::MODE_FILTER)
            begin
                q_push = 1'b1;
                if (words.payload.end_of_packet)
                begin
                    mode_next = fir_ibcl_pkg::MODE_IDLE;
                    idx_next  = '0;
                end
            end
            else if (words.payload.end_of_packet)
            begin
                q_push      = 1'b1;
                q_entry.cmd = fir_ibcl_pkg::CMD_ABORT;
                mode_next   = fir_ibcl_pkg::MODE_IDLE;
                idx_next    = '0;
            end
            else
            begin
                case (mode_reg)
                    fir_ibcl_pkg::MODE_IDLE:
                    begin
                        if (words.payload.word == fir_ibcl_pkg::START_MARK)
                        begin
                            mode_next = fir_ibcl_pkg::MODE_LOAD;
                            idx_next  = '0;
                        end
                    end
                    fir_ibcl_pkg::MODE_LOAD:
                    begin
                        q_push      = 1'b1;
                        q_entry.cmd = fir_ibcl_pkg::CMD_COEF;
                        if (idx_reg == IDX_W'(TAPS - 1))
                        begin
                            mode_next = fir_ibcl_pkg::MODE_AWAIT;
                            idx_next  = '0;
                        end
                        else
                        begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                    fir_ibcl_pkg::MODE_AWAIT:
                    begin
                        if (words.payload.word == fir_ibcl_pkg::RUN_MARK)
                        begin
                            mode_next = fir_ibcl_pkg::MODE_FILTER;
                        end
                        else
                        begin
                            mode_next = fir_ibcl_pkg::MODE_LOAD;
                        end
                        idx_next = '0;
                    end
                    default:
                    begin
                        mode_next = fir_ibcl_pkg::MODE_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

// ===== hw/rtl/fir_ibcl_queue.sv =====
// Two-entry command queue between the front end and the back end.
module fir_ibcl_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  fir_ibcl_pkg::cmd_entry_t      push_entry,
    output logic                          full,
    input  logic                          pop,
    output fir_ibcl_pkg::queue_head_t     head
);

    localparam int PTR_W = $clog2(fir_ibcl_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(fir_ibcl_pkg::QUEUE_DEPTH + 1);

    fir_ibcl_pkg::cmd_entry_t entry_reg [fir_ibcl_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]         count_reg;
    logic                     do_push, do_pop;

    assign full       = count_reg == CNT_W'(fir_ibcl_pkg::QUEUE_DEPTH);
    assign head.valid = count_reg != '0;
    assign head.entry = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head.valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/fir_ibcl_back.sv =====
// Back end: stores coefficients, runs the tap-serial MAC and holds the result.
module fir_ibcl_back #(
    parameter int TAPS         = 64,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fir_ibcl_pkg::queue_head_t     head,
    output logic                          pop,
    fir_ibcl_out_if.source                results
);

    localparam int IDX_W  = $clog2(TAPS);
    localparam int CNT_W  = $clog2(TAPS + 1);
    localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W  = fir_ibcl_pkg::RESULT_W;

    fir_ibcl_pkg::back_state_t state_reg, state_next;
    logic [IDX_W-1:0]          k_reg, k_next;
    logic [IDX_W-1:0]          ptr_reg, ptr_next;
    logic [IDX_W-1:0]          wp_reg, wp_next;
    logic [CNT_W-1:0]          fill_reg, fill_next;
    logic [TAPS-1:0]           coef_vld_reg, coef_vld_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic                      eop_reg, eop_next;
    logic                      out_valid_reg, out_valid_next;
    fir_ibcl_pkg::out_t        out_data_reg, out_data_next;

    logic                      s1_valid_reg, s1_last_reg, s1_cvld_reg, s1_dvld_reg;
    logic                      s2_valid_reg, s2_last_reg;
    logic signed [PROD_W-1:0]  prod_reg;

    logic                      issue;
    logic                      out_free;
    logic                      coef_we, dly_we;
    logic [IDX_W-1:0]          coef_waddr, wp_dec;
    logic [COEF_WIDTH-1:0]     coef_rd;
    logic [SAMPLE_WIDTH-1:0]   dly_rd;
    logic signed [COEF_WIDTH-1:0]   coef_op;
    logic signed [SAMPLE_WIDTH-1:0] dly_op;

    assign out_free        = !out_valid_reg || results.ready;
    assign results.valid   = out_valid_reg;
    assign results.payload = out_data_reg;
    assign coef_waddr      = IDX_W'(head.entry.addr);
    assign wp_dec          = (wp_reg == '0) ? IDX_W'(TAPS - 1) : wp_reg - IDX_W'(1);

    fir_ibcl_ram #(
        .WIDTH (COEF_WIDTH),
        .DEPTH (TAPS)
    ) u_coef_ram (
        .clk     (clk),
        .wr_en   (coef_we),
        .wr_addr (coef_waddr),
        .wr_data (head.entry.word[COEF_WIDTH-1:0]),
        .rd_addr (k_reg),
        .rd_data (coef_rd)
    );

    fir_ibcl_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (TAPS)
    ) u_delay_ram (
        .clk     (clk),
        .wr_en   (dly_we),
        .wr_addr (wp_dec),
        .wr_data (head.entry.word[SAMPLE_WIDTH-1:0]),
        .rd_addr (ptr_reg),
        .rd_data (dly_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fir_ibcl_pkg::BACK_IDLE;
            k_reg         <= '0;
            ptr_reg       <= '0;
            wp_reg        <= '0;
            fill_reg      <= '0;
            coef_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            ptr_reg       <= ptr_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            coef_vld_reg  <= coef_vld_next;
            out_valid_reg <= out_valid_next;
            s1_valid_reg  <= issue;
            s1_last_reg   <= issue && (k_reg == IDX_W'(TAPS - 1));
            s2_valid_reg  <= s1_valid_reg;
            s2_last_reg   <= s1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        eop_reg      <= eop_next;
        out_data_reg <= out_data_next;
        s1_cvld_reg  <= coef_vld_reg[k_reg];
        s1_dvld_reg  <= CNT_W'(k_reg) < fill_reg;
        prod_reg     <= coef_op * dly_op;
    end

    always_comb
    begin
        coef_op = s1_cvld_reg ? $signed(coef_rd) : '0;
        dly_op  = s1_dvld_reg ? $signed(dly_rd) : '0;
    end

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        ptr_next       = ptr_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        coef_vld_next  = coef_vld_reg;
        acc_next       = s2_valid_reg ? acc_reg + ACC_W'(prod_reg) : acc_reg;
        eop_next       = eop_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        issue          = 1'b0;
        coef_we        = 1'b0;
        dly_we         = 1'b0;
        case (state_reg)
            fir_ibcl_pkg::BACK_IDLE:
            begin
                if (head.valid)
                begin
                    case (head.entry.cmd)
                        fir_ibcl_pkg::CMD_COEF:
                        begin
                            pop                       = 1'b1;
                            coef_we                   = 1'b1;
                            coef_vld_next[coef_waddr] = 1'b1;
                        end
                        fir_ibcl_pkg::CMD_SAMPLE:
                        begin
                            pop        = 1'b1;
                            dly_we     = 1'b1;
                            wp_next    = wp_dec;
                            ptr_next   = wp_dec;
                            k_next     = '0;
                            acc_next   = '0;
                            eop_next   = head.entry.last;
                            state_next = fir_ibcl_pkg::BACK_MAC;
                            if (fill_reg != CNT_W'(TAPS))
                            begin
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                        fir_ibcl_pkg::CMD_ABORT:
                        begin
                            if (out_free)
                            begin
                                pop                    = 1'b1;
                                out_valid_next         = 1'b1;
                                out_data_next.filtered = '0;
                                out_data_next.last_out = 1'b1;
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            fir_ibcl_pkg::BACK_MAC:
            begin
                issue    = 1'b1;
                ptr_next = (ptr_reg == IDX_W'(TAPS - 1)) ? '0 : ptr_reg + IDX_W'(1);
                if (k_reg == IDX_W'(TAPS - 1))
                begin
                    state_next = fir_ibcl_pkg::BACK_DRAIN;
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            fir_ibcl_pkg::BACK_DRAIN:
            begin
                if (s2_valid_reg && s2_last_reg)
                begin
                    state_next = fir_ibcl_pkg::BACK_RESULT;
                end
            end
            fir_ibcl_pkg::BACK_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_data_next.filtered = acc_reg;
                    out_data_next.last_out = eop_reg;
                    state_next             = fir_ibcl_pkg::BACK_IDLE;
                end
            end
            default:
            begin
                state_next = fir_ibcl_pkg::BACK_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/fir_filter_inband_coef_load.sv =====
// Top level of the streaming FIR filter with in-band coefficient load.
//
// words carries 32-bit stream words with an end_of_packet flag; results
// carries 40-bit sums with last_out. A packet opens with 0xBEEF, then TAPS
// coefficients (highest tap first), then 0xABBA, then samples. Each sample
// gives one sum; a last word outside the sample phase gives a zero result
// marked last.
// The front end takes one word per cycle while its two-entry command queue
// has room. The back end writes a coefficient into its RAM. For a sample it
// runs one multiply-accumulate per tap through the coefficient and delay
// RAMs, plus the read, product and result stages; it takes no new command
// until the sum is in the output register. An abort waits for that register.
// Results sit in an output register; while the receiver stalls the back end
// holds its finished sum and the queue fills, then words.ready drops.
// Reset returns to idle and clears the coefficient valid bits and the delay
// fill count, so all taps and delayed samples read as zero until written.
module fir_filter_inband_coef_load #(
    parameter int TAPS         = 64,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    fir_ibcl_in_if.sink    words,
    fir_ibcl_out_if.source results
);

    logic                      q_push;
    logic                      q_full;
    logic                      q_pop;
    fir_ibcl_pkg::cmd_entry_t  q_entry;
    fir_ibcl_pkg::queue_head_t q_head;

    fir_ibcl_front #(
        .TAPS (TAPS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .words   (words),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    fir_ibcl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head)
    );

    fir_ibcl_back #(
        .TAPS         (TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (q_head),
        .pop     (q_pop),
        .results (results)
    );

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head.valid)
        else $error("pop from empty command queue");

    a_push_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> words.valid && words.ready)
        else $error("command pushed without an input transfer");

    a_abort_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && q_entry.cmd == fir_ibcl_pkg::CMD_ABORT |-> words.payload.end_of_packet)
        else $error("abort command from a word not marked last");

    a_abort_result: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && q_head.entry.cmd == fir_ibcl_pkg::CMD_ABORT
        |=> results.valid && results.payload.filtered == '0 && results.payload.last_out)
        else $error("aborted packet did not yield a zero last result");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench: in-band coefficient loads, FIR sums and aborted packets.
module tb;

    localparam int TAPS         = 64;
    localparam int SAMPLE_WIDTH = 16;
    localparam int COEF_WIDTH   = 16;
    localparam int LONG_HOLD    = 600;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_WORDS = 760;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    fir_ibcl_in_if  words_ch ();
    fir_ibcl_out_if results_ch ();

    logic              in_valid  = 1'b0;
    fir_ibcl_pkg::in_t in_payload = '0;
    logic              out_ready = 1'b0;

    assign words_ch.valid   = in_valid;
    assign words_ch.payload = in_payload;
    assign results_ch.ready = out_ready;

    fir_filter_inband_coef_load #(
        .TAPS         (TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .words   (words_ch),
        .results (results_ch)
    );

    fir_ibcl_pkg::in_t   pending_words[$];
    fir_ibcl_pkg::out_t  sums_due[$];
    fir_ibcl_pkg::out_t  want_sum;
    int    errors      = 0;
    int    words_taken = 0;
    int    in_gap      = 0;
    int    in_quiet    = 0;
    int    out_hold    = 0;
    int    out_quiet   = 0;
    int    hold_req    = 0;
    int    hold_served = 0;
    int    idle_cycles = 0;

    fir_ibcl_pkg::mode_t            fir_mode = fir_ibcl_pkg::MODE_IDLE;
    int                             coefs_loaded = 0;
    logic signed [COEF_WIDTH-1:0]   coef_q [TAPS] = '{default: '0};
    logic signed [SAMPLE_WIDTH-1:0] delay_q [TAPS] = '{default: '0};

    task automatic fir_step(input fir_ibcl_pkg::in_t item);
        longint             acc;
        logic [31:0]        w;
        fir_ibcl_pkg::out_t r;
        int                 k;
        w = item.word;
        acc = 0;
        if (fir_mode == fir_ibcl_pkg::MODE_FILTER)
        begin
            for (k = TAPS - 1; k > 0; k--)
                delay_q[k] = delay_q[k-1];
            delay_q[0] = w[SAMPLE_WIDTH-1:0];
            for (k = 0; k < TAPS; k++)
                acc += longint'(coef_q[k]) * longint'(delay_q[k]);
            r.filtered = acc[fir_ibcl_pkg::RESULT_W-1:0];
            r.last_out = item.end_of_packet;
            sums_due.push_back(r);
            if (item.end_of_packet)
            begin
                fir_mode = fir_ibcl_pkg::MODE_IDLE;
                coefs_loaded = 0;
            end
        end
        else if (item.end_of_packet)
        begin
            r.filtered = '0;
            r.last_out = 1'b1;
            sums_due.push_back(r);
            fir_mode = fir_ibcl_pkg::MODE_IDLE;
            coefs_loaded = 0;
        end
        else
        begin
            case (fir_mode)
                fir_ibcl_pkg::MODE_IDLE:
                begin
                    if (w == fir_ibcl_pkg::START_MARK)
                    begin
                        fir_mode = fir_ibcl_pkg::MODE_LOAD;
                        coefs_loaded = 0;
                    end
                end
                fir_ibcl_pkg::MODE_LOAD:
                begin
                    coef_q[TAPS-1-coefs_loaded] = w[COEF_WIDTH-1:0];
                    coefs_loaded++;
                    if (coefs_loaded >= TAPS)
                    begin
                        fir_mode = fir_ibcl_pkg::MODE_AWAIT;
                        coefs_loaded = 0;
                    end
                end
                default:
                begin
                    fir_mode = (w == fir_ibcl_pkg::RUN_MARK) ? fir_ibcl_pkg::MODE_FILTER
                                                             : fir_ibcl_pkg::MODE_LOAD;
                    coefs_loaded = 0;
                end
            endcase
        end
    endtask

    task automatic note_mismatch(input string msg);
        errors++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    function automatic int next_gap(input int idle_pct, inout int quiet);
        int r;
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 199) == 0)
        begin
            quiet = $urandom_range(30, 120);
            return 0;
        end
        if ($urandom_range(0, 99) >= idle_pct)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 93)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_value();
        logic [15:0] hi;
        hi = 16'($urandom());
        case ($urandom_range(0, 9))
            0: return {hi, 16'h7FFF};
            1: return {hi, 16'h8000};
            2: return {hi, 16'hFFFF};
            3: return {hi, 16'h0000};
            4: return 32'($urandom_range(0, 15)) - 32'd8;
            default: return $urandom();
        endcase
    endfunction

    task automatic add_word(input logic [31:0] w, input logic eop);
        fir_ibcl_pkg::in_t item;
        item.word = w;
        item.end_of_packet = eop;
        pending_words.push_back(item);
    endtask

    task automatic add_coefs(input int n);
        repeat (n) add_word(pick_value(), 1'b0);
    endtask

    task automatic add_samples(input int n);
        int i;
        for (i = 0; i < n; i++)
            add_word(pick_value(), i == n - 1);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_payload <= '0;
        end
        else
        begin
            if (in_valid && words_ch.ready)
            begin
                fir_step(in_payload);
                words_taken++;
            end
            if (!in_valid || words_ch.ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    in_payload <= pending_words.pop_front();
                    in_valid   <= 1'b1;
                    in_gap = next_gap(40, in_quiet);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (results_ch.valid && out_ready)
            begin
                if (sums_due.size() == 0)
                    note_mismatch($sformatf("unexpected result %h", results_ch.payload));
                else
                begin
                    want_sum = sums_due.pop_front();
                    if (results_ch.payload.filtered !== want_sum.filtered)
                        note_mismatch($sformatf("filtered %0d, want %0d",
                            results_ch.payload.filtered, want_sum.filtered));
                    if (results_ch.payload.last_out !== want_sum.last_out)
                        note_mismatch($sformatf("last_out %b, want %b",
                            results_ch.payload.last_out, want_sum.last_out));
                end
            end
            if (hold_req != hold_served)
            begin
                hold_served++;
                out_hold = LONG_HOLD;
            end
            if (out_hold == 0)
                out_hold = next_gap(6, out_quiet);
            if (out_hold > 0)
            begin
                out_hold--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && words_ch.ready) || (results_ch.valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        int          r;
        int          k;
        int          directed_n;
        logic [31:0] w;

        add_word(32'h0000_0000, 1'b1);
        add_word(fir_ibcl_pkg::START_MARK, 1'b1);
        add_word(32'h0001_BEEF, 1'b0);
        add_word(fir_ibcl_pkg::RUN_MARK, 1'b0);
        add_word(fir_ibcl_pkg::START_MARK, 1'b0);
        add_coefs(5);
        add_word(32'h0000_0000, 1'b1);
        add_word(fir_ibcl_pkg::START_MARK, 1'b0);
        add_coefs(TAPS);
        add_word(32'h0001_ABBA, 1'b0);
        add_coefs(TAPS);
        add_word(fir_ibcl_pkg::RUN_MARK, 1'b1);

        add_word(fir_ibcl_pkg::START_MARK, 1'b0);
        for (k = 0; k < TAPS; k++)
            add_word({16'($urandom()), (k < TAPS / 2) ? 16'h8000 : 16'h7FFF}, 1'b0);
        add_word(fir_ibcl_pkg::RUN_MARK, 1'b0);
        add_word(32'h8000_0000, 1'b0);
        add_word(32'h7FFF_FFFF, 1'b0);
        add_word(32'hA5A5_8000, 1'b0);
        add_word(32'h0000_7FFF, 1'b0);
        add_word(32'hFFFF_8000, 1'b1);

        add_word(fir_ibcl_pkg::START_MARK, 1'b0);
        repeat (TAPS) add_word({16'($urandom()), 16'h8000}, 1'b0);
        add_word(fir_ibcl_pkg::RUN_MARK, 1'b0);
        for (k = 0; k <= TAPS; k++)
            add_word({16'($urandom()), 16'h8000}, k == TAPS);

        directed_n = pending_words.size();
        while (pending_words.size() < directed_n + RANDOM_WORDS)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                add_word(fir_ibcl_pkg::START_MARK, 1'b0);
                add_coefs(TAPS);
                add_word(fir_ibcl_pkg::RUN_MARK, 1'b0);
                add_samples($urandom_range(1, 40));
            end
            else if (r < 80)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    case ($urandom_range(0, 3))
                        0: w = fir_ibcl_pkg::START_MARK | 32'(1 << $urandom_range(16, 31));
                        1: w = fir_ibcl_pkg::RUN_MARK;
                        2: w = 32'h0001_BEEF;
                        default: w = $urandom();
                    endcase
                    add_word(w, $urandom_range(0, 9) == 0);
                end
            end
            else
            begin
                add_word(fir_ibcl_pkg::START_MARK, 1'b0);
                k = $urandom_range(0, TAPS);
                add_coefs(k);
                if (k < TAPS)
                    add_word(pick_value(), 1'b1);
                else
                begin
                    w = pick_value();
                    if (w == fir_ibcl_pkg::RUN_MARK)
                        w[16] = 1'b1;
                    case ($urandom_range(0, 2))
                        0: add_word(w, 1'b1);
                        1:
                        begin
                            add_word(w, 1'b0);
                            add_coefs($urandom_range(0, TAPS - 1));
                            add_word(pick_value(), 1'b1);
                        end
                        default:
                        begin
                            add_word(w, 1'b0);
                            add_coefs(TAPS);
                            add_word(fir_ibcl_pkg::RUN_MARK, 1'b0);
                            add_samples($urandom_range(1, 8));
                        end
                    endcase
                end
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (words_taken < directed_n + 400)
            @(negedge clk);
        hold_req = hold_req + 1;

        while (pending_words.size() > 0 || in_valid)
            @(negedge clk);
        while (sums_due.size() > 0)
            @(negedge clk);
        repeat (2 * TAPS + 16) @(negedge clk);

        if (errors == 0 && sums_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
